@@ design/dec_pkg.sv @@
// ----------------------------------------------------------------------------
// dec_pkg: shared types, constants and helpers for the disc collision block
// Holds the beat formats of both channels, the fixed-point constants, the
// register map and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package dec_pkg;

  // Fixed-point layout of positions and velocities.
  localparam int FRAC_BITS   = 8;
  localparam int SQRT_EXTRA  = 7;
  localparam int UNIT_BITS   = 30;
  localparam int VAL_W       = 24;
  localparam int MASS_W      = 12;
  localparam int DIAM_W      = 8;

  // Pipelined arithmetic units.
  localparam int SQRT_W      = 23;   // root bits of the distance
  localparam int DIV_NUM_W   = 54;   // separation and unit-normal dividers
  localparam int DIV_DEN_W   = 24;
  localparam int DIV_QUO_W   = 31;
  localparam int MDIV_NUM_W  = 42;   // mass-weighted normal velocity dividers
  localparam int MDIV_DEN_W  = 13;
  localparam int MDIV_QUO_W  = 28;

  // Configuration register map.
  localparam int ADDR_W                 = 3;
  localparam int DATA_W                 = 32;
  localparam logic [0:0] REG_DISC_DIAM  = 1'b0;
  localparam logic [DIAM_W-1:0] DIAM_RESET = 8'd38;

  typedef struct packed {
    logic signed [VAL_W-1:0] a_pos_x;
    logic signed [VAL_W-1:0] a_pos_y;
    logic signed [VAL_W-1:0] a_vel_x;
    logic signed [VAL_W-1:0] a_vel_y;
    logic [MASS_W-1:0]       a_mass;
    logic signed [VAL_W-1:0] b_pos_x;
    logic signed [VAL_W-1:0] b_pos_y;
    logic signed [VAL_W-1:0] b_vel_x;
    logic signed [VAL_W-1:0] b_vel_y;
    logic [MASS_W-1:0]       b_mass;
    logic                    both_visible;
    logic                    a_in_hand;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_a_pos_x;
    logic signed [VAL_W-1:0] new_a_pos_y;
    logic signed [VAL_W-1:0] new_a_vel_x;
    logic signed [VAL_W-1:0] new_a_vel_y;
    logic signed [VAL_W-1:0] new_b_pos_x;
    logic signed [VAL_W-1:0] new_b_pos_y;
    logic signed [VAL_W-1:0] new_b_vel_x;
    logic signed [VAL_W-1:0] new_b_vel_y;
    logic                    contact;
    logic                    resolved;
  } out_t;

  // Divide by 2^UNIT_BITS, rounding half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // Clamp to the signed 24-bit range.
  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/dec_isqrt.sv @@
// ----------------------------------------------------------------------------
// dec_isqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per register stage. The
// floor root of x leaves the last stage.
// ----------------------------------------------------------------------------
module dec_isqrt #(
  parameter int ROOT_W = 23
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   x,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = 2 * ROOT_W + 1;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = REM_W'(x);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // Growth of the square when bit B of the root is set.
    assign trial = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? rem_in - trial : rem_in;
      root_r[k] <= take ? root_in | (ROOT_W'(1) << B) : root_in;
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

@@ design/dec_div.sv @@
// ----------------------------------------------------------------------------
// dec_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The caller keeps
// the quotient below 2^QUO_W; the floor quotient leaves the last stage.
// ----------------------------------------------------------------------------
module dec_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 24,
  parameter int QUO_W = 31
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int REM_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

  logic [REM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [REM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [REM_W-1:0] sub;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Try the divisor at weight 2^B.
    assign sub  = REM_W'(den_in) << B;
    assign take = rem_in >= sub;

    always_ff @(posedge clk) begin
      rem_r[k] <= take ? rem_in - sub : rem_in;
      den_r[k] <= den_in;
      quo_r[k] <= take ? quo_in | (QUO_W'(1) << B) : quo_in;
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

@@ design/disc_elastic_collision.sv @@
// ----------------------------------------------------------------------------
// disc_elastic_collision: contact test and elastic collision of two discs
// Fully pipelined; one disc pair may enter in every cycle.
// ----------------------------------------------------------------------------
// Usage. Present a disc pair on in_data and raise start; the beat is taken at
// that clock edge. busy is always low, so a new pair may follow every cycle.
// Exactly one result beat comes back per input beat, in order, on out_data
// with out_valid high for one cycle. The pipeline depth is set by the
// 23-stage square root and the two dividers in series
// (31 stages for the unit normal and separation, 28 for the mass weighting),
// plus multiply and rounding stages around them. Throughput is one pair per
// cycle. The receiver cannot stall: results are shown once and not held.
// The disc diameter register sits at byte address 0 of the APB port and may
// be changed only while no pair is in flight. Synchronous reset clears all
// valid bits and restores the diameter to 38 pixels; data in flight is lost.
// ----------------------------------------------------------------------------
module disc_elastic_collision (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  dec_pkg::in_t                   in_data,
  output logic                           out_valid,
  output dec_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dec_pkg::ADDR_W-1:0]     paddr,
  input  logic [dec_pkg::DATA_W-1:0]     pwdata,
  output logic [dec_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  // Stage numbers: a value named at stage s sits in the register of pipeline stage s.
  localparam int ST_D2  = 3;
  localparam int ST_DQ  = ST_D2 + dec_pkg::SQRT_W;
  localparam int ST_OV  = ST_DQ + 1;
  localparam int ST_NUM = ST_OV + 1;
  localparam int ST_Q   = ST_NUM + dec_pkg::DIV_QUO_W;
  localparam int ST_U   = ST_Q + 1;
  localparam int ST_P1  = ST_U + 1;
  localparam int ST_S1  = ST_P1 + 1;
  localparam int ST_VN  = ST_S1 + 1;
  localparam int ST_MP  = ST_VN + 1;
  localparam int ST_MS  = ST_MP + 1;
  localparam int ST_MN  = ST_MS + 1;
  localparam int ST_MQ  = ST_MN + dec_pkg::MDIV_QUO_W;
  localparam int ST_V2  = ST_MQ + 1;
  localparam int ST_P2  = ST_V2 + 1;
  localparam int ST_S2  = ST_P2 + 1;
  localparam int ST_VEL = ST_S2 + 1;
  localparam int ST_OUT = ST_VEL + 1;

  typedef struct packed {
    logic [12:0]        ms;
    logic signed [12:0] dm;
    logic [12:0]        m1x2;
    logic [12:0]        m2x2;
  } mass_t;

  typedef struct packed {
    logic contact;
    logic resolve;
  } flag_t;

  // --------------------------------------------------------------------------
  // Configuration port.
  logic [dec_pkg::DIAM_W-1:0] diam_r;
  logic                       reg_hit;
  logic [15:0]                dfix;
  logic [31:0]                dfix2;

  assign reg_hit = paddr[dec_pkg::ADDR_W-1:2] == dec_pkg::REG_DISC_DIAM;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? dec_pkg::DATA_W'(diam_r) : '0;
  assign dfix    = {diam_r, 8'd0};
  assign dfix2   = 32'(dfix) * 32'(dfix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r <= dec_pkg::DIAM_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      diam_r <= pwdata[dec_pkg::DIAM_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits and the delay lines that travel beside the arithmetic.
  logic                      vld_r   [ST_OUT];
  dec_pkg::in_t              pay_r   [ST_VEL];
  logic signed [24:0]        dx_d    [ST_Q-1];
  logic signed [24:0]        dy_d    [ST_Q-1];
  mass_t                     mass_d  [ST_MS-1];
  flag_t                     flag_d  [ST_VEL-3];
  logic signed [31:0]        ux_d    [ST_V2-ST_U+1];
  logic signed [31:0]        uy_d    [ST_V2-ST_U+1];
  logic signed [25:0]        v1t_d   [ST_V2-ST_VN+1];
  logic signed [25:0]        v2t_d   [ST_V2-ST_VN+1];
  logic [1:0]                sgn_d   [ST_MQ-ST_MN+1];
  logic signed [24:0]        npos_d  [ST_VEL-ST_P1+1][4];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ST_OUT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k < ST_OUT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: input beat capture; the payload rides along to the output mux.
  always_ff @(posedge clk) begin
    pay_r[0] <= in_data;
    for (int k = 1; k < ST_VEL; k++) begin
      pay_r[k] <= pay_r[k-1];
    end
  end

  // Stage 2: center differences and mass terms.
  logic signed [24:0] dx_nxt, dy_nxt;
  logic [11:0]        m1, m2;
  mass_t              mass_nxt;

  always_comb begin
    dx_nxt = {pay_r[0].a_pos_x[23], pay_r[0].a_pos_x}
           - {pay_r[0].b_pos_x[23], pay_r[0].b_pos_x};
    dy_nxt = {pay_r[0].a_pos_y[23], pay_r[0].a_pos_y}
           - {pay_r[0].b_pos_y[23], pay_r[0].b_pos_y};
    m1 = pay_r[0].a_mass;
    m2 = pay_r[0].b_mass;
    // Two massless discs behave as equal unit masses.
    if (m1 == '0 && m2 == '0) begin
      m1 = 12'd1;
      m2 = 12'd1;
    end
    mass_nxt.ms   = 13'(m1) + 13'(m2);
    mass_nxt.dm   = $signed({1'b0, m1}) - $signed({1'b0, m2});
    mass_nxt.m1x2 = {m1, 1'b0};
    mass_nxt.m2x2 = {m2, 1'b0};
  end

  always_ff @(posedge clk) begin
    dx_d[0]   <= dx_nxt;
    dy_d[0]   <= dy_nxt;
    mass_d[0] <= mass_nxt;
    for (int k = 1; k < ST_Q - 1; k++) begin
      dx_d[k] <= dx_d[k-1];
      dy_d[k] <= dy_d[k-1];
    end
    for (int k = 1; k < ST_MS - 1; k++) begin
      mass_d[k] <= mass_d[k-1];
    end
  end

  // Stage 3: squared center distance.
  logic signed [49:0] dxx, dyy;
  logic [49:0]        d2_r;

  assign dxx = 50'(dx_d[0]) * 50'(dx_d[0]);
  assign dyy = 50'(dy_d[0]) * 50'(dy_d[0]);

  always_ff @(posedge clk) begin
    d2_r <= $unsigned(dxx) + $unsigned(dyy);
  end

  // Stage 4: contact test. Coincident centers and a held disc A touch but
  // are left alone.
  flag_t flag_nxt;

  always_comb begin
    flag_nxt.contact = pay_r[ST_D2-1].both_visible && (d2_r <= 50'(dfix2));
    flag_nxt.resolve = flag_nxt.contact && !pay_r[ST_D2-1].a_in_hand && (d2_r != '0);
  end

  always_ff @(posedge clk) begin
    flag_d[0] <= flag_nxt;
    for (int k = 1; k < ST_VEL - 3; k++) begin
      flag_d[k] <= flag_d[k-1];
    end
  end

  // Distance in Q(FRAC_BITS+7). Inside contact d2 fits in 32 bits.
  logic [dec_pkg::SQRT_W-1:0] dq;

  dec_isqrt #(
    .ROOT_W (dec_pkg::SQRT_W)
  ) u_isqrt (
    .clk  (clk),
    .x    ({d2_r[31:0], 14'd0}),
    .root (dq)
  );

  // Overlap along the normal.
  logic [22:0] ov_r, dq_ov_r;

  always_ff @(posedge clk) begin
    ov_r    <= {dfix, 7'd0} - dq;
    dq_ov_r <= dq;
  end

  // Rounded-division numerators for the separation and the unit normal.
  logic [24:0] adx_w, ady_w;
  logic [16:0] adx, ady;
  logic [39:0] sxp, syp;
  logic [dec_pkg::DIV_NUM_W-1:0] nsx_r, nsy_r, nux_r, nuy_r;
  logic [dec_pkg::DIV_DEN_W-1:0] dens_r, denu_r;

  always_comb begin
    adx_w = dx_d[ST_OV-2][24] ? 25'(-dx_d[ST_OV-2]) : 25'(dx_d[ST_OV-2]);
    ady_w = dy_d[ST_OV-2][24] ? 25'(-dy_d[ST_OV-2]) : 25'(dy_d[ST_OV-2]);
    adx   = adx_w[16:0];
    ady   = ady_w[16:0];
    sxp   = 40'(adx) * 40'(ov_r);
    syp   = 40'(ady) * 40'(ov_r);
  end

  always_ff @(posedge clk) begin
    nsx_r  <= dec_pkg::DIV_NUM_W'(sxp) + dec_pkg::DIV_NUM_W'(dq_ov_r);
    nsy_r  <= dec_pkg::DIV_NUM_W'(syp) + dec_pkg::DIV_NUM_W'(dq_ov_r);
    nux_r  <= {adx, 37'd0} + dec_pkg::DIV_NUM_W'(dq_ov_r >> 1);
    nuy_r  <= {ady, 37'd0} + dec_pkg::DIV_NUM_W'(dq_ov_r >> 1);
    dens_r <= {dq_ov_r, 1'b0};
    denu_r <= {1'b0, dq_ov_r};
  end

  logic [dec_pkg::DIV_QUO_W-1:0] qsx, qsy, qux, quy;

  dec_div #(
    .NUM_W (dec_pkg::DIV_NUM_W),
    .DEN_W (dec_pkg::DIV_DEN_W),
    .QUO_W (dec_pkg::DIV_QUO_W)
  ) u_div_sx (
    .clk (clk), .num (nsx_r), .den (dens_r), .quo (qsx)
  );

  dec_div #(
    .NUM_W (dec_pkg::DIV_NUM_W),
    .DEN_W (dec_pkg::DIV_DEN_W),
    .QUO_W (dec_pkg::DIV_QUO_W)
  ) u_div_sy (
    .clk (clk), .num (nsy_r), .den (dens_r), .quo (qsy)
  );

  dec_div #(
    .NUM_W (dec_pkg::DIV_NUM_W),
    .DEN_W (dec_pkg::DIV_DEN_W),
    .QUO_W (dec_pkg::DIV_QUO_W)
  ) u_div_ux (
    .clk (clk), .num (nux_r), .den (denu_r), .quo (qux)
  );

  dec_div #(
    .NUM_W (dec_pkg::DIV_NUM_W),
    .DEN_W (dec_pkg::DIV_DEN_W),
    .QUO_W (dec_pkg::DIV_QUO_W)
  ) u_div_uy (
    .clk (clk), .num (nuy_r), .den (denu_r), .quo (quy)
  );

  // Signed unit normal (Q30) and separation.
  logic               xneg, yneg;
  logic signed [31:0] uxq, uyq;
  logic signed [16:0] sxq, syq;
  logic signed [16:0] sx_r, sy_r;

  always_comb begin
    xneg = dx_d[ST_Q-2][24];
    yneg = dy_d[ST_Q-2][24];
    uxq  = $signed({1'b0, qux});
    uyq  = $signed({1'b0, quy});
    sxq  = $signed({1'b0, qsx[15:0]});
    syq  = $signed({1'b0, qsy[15:0]});
  end

  always_ff @(posedge clk) begin
    ux_d[0] <= xneg ? -uxq : uxq;
    uy_d[0] <= yneg ? -uyq : uyq;
    sx_r    <= xneg ? -sxq : sxq;
    sy_r    <= yneg ? -syq : syq;
    for (int k = 1; k <= ST_V2 - ST_U; k++) begin
      ux_d[k] <= ux_d[k-1];
      uy_d[k] <= uy_d[k-1];
    end
  end

  // Projections onto normal and tangent, and the separated positions.
  dec_pkg::in_t       pu;
  logic signed [55:0] prj_r [8];

  assign pu = pay_r[ST_U-1];

  always_ff @(posedge clk) begin
    prj_r[0] <= 56'(ux_d[0]) * 56'(pu.a_vel_x);
    prj_r[1] <= 56'(uy_d[0]) * 56'(pu.a_vel_y);
    prj_r[2] <= 56'(ux_d[0]) * 56'(pu.a_vel_y);
    prj_r[3] <= 56'(uy_d[0]) * 56'(pu.a_vel_x);
    prj_r[4] <= 56'(ux_d[0]) * 56'(pu.b_vel_x);
    prj_r[5] <= 56'(uy_d[0]) * 56'(pu.b_vel_y);
    prj_r[6] <= 56'(ux_d[0]) * 56'(pu.b_vel_y);
    prj_r[7] <= 56'(uy_d[0]) * 56'(pu.b_vel_x);
    npos_d[0][0] <= {pu.a_pos_x[23], pu.a_pos_x} + 25'(sx_r);
    npos_d[0][1] <= {pu.a_pos_y[23], pu.a_pos_y} + 25'(sy_r);
    npos_d[0][2] <= {pu.b_pos_x[23], pu.b_pos_x} - 25'(sx_r);
    npos_d[0][3] <= {pu.b_pos_y[23], pu.b_pos_y} - 25'(sy_r);
    for (int k = 1; k <= ST_VEL - ST_P1; k++) begin
      npos_d[k] <= npos_d[k-1];
    end
  end

  logic signed [56:0] sm_r [4];

  always_ff @(posedge clk) begin
    sm_r[0] <= 57'(prj_r[0]) + 57'(prj_r[1]);
    sm_r[1] <= 57'(prj_r[2]) - 57'(prj_r[3]);
    sm_r[2] <= 57'(prj_r[4]) + 57'(prj_r[5]);
    sm_r[3] <= 57'(prj_r[6]) - 57'(prj_r[7]);
  end

  logic signed [25:0] v1n_r, v2n_r;

  always_ff @(posedge clk) begin
    v1n_r    <= 26'(dec_pkg::rnd_shr(64'(sm_r[0])));
    v1t_d[0] <= 26'(dec_pkg::rnd_shr(64'(sm_r[1])));
    v2n_r    <= 26'(dec_pkg::rnd_shr(64'(sm_r[2])));
    v2t_d[0] <= 26'(dec_pkg::rnd_shr(64'(sm_r[3])));
    for (int k = 1; k <= ST_V2 - ST_VN; k++) begin
      v1t_d[k] <= v1t_d[k-1];
      v2t_d[k] <= v2t_d[k-1];
    end
  end

  // Mass-weighted normal velocities: products, then sums.
  mass_t              mp;
  logic signed [39:0] a1_r, b1_r, a2_r, b2_r;

  assign mp = mass_d[ST_VN-2];

  always_ff @(posedge clk) begin
    a1_r <= 40'(v1n_r) * 40'(mp.dm);
    b1_r <= 40'(v2n_r) * 40'($signed({1'b0, mp.m2x2}));
    a2_r <= 40'(v2n_r) * (-40'(mp.dm));
    b2_r <= 40'(v1n_r) * 40'($signed({1'b0, mp.m1x2}));
  end

  logic signed [41:0] n1_r, n2_r;

  always_ff @(posedge clk) begin
    n1_r <= 42'(a1_r) + 42'(b1_r);
    n2_r <= 42'(a2_r) + 42'(b2_r);
  end

  // Rounded division by the mass sum.
  logic [dec_pkg::MDIV_NUM_W-1:0] mn1_r, mn2_r;
  logic [dec_pkg::MDIV_DEN_W-1:0] ms_r;
  logic [12:0]                    ms_half;

  assign ms_half = mass_d[ST_MS-2].ms >> 1;

  always_ff @(posedge clk) begin
    mn1_r    <= (n1_r[41] ? 42'(-n1_r) : 42'(n1_r)) + 42'(ms_half);
    mn2_r    <= (n2_r[41] ? 42'(-n2_r) : 42'(n2_r)) + 42'(ms_half);
    ms_r     <= mass_d[ST_MS-2].ms;
    sgn_d[0] <= {n1_r[41], n2_r[41]};
    for (int k = 1; k <= ST_MQ - ST_MN; k++) begin
      sgn_d[k] <= sgn_d[k-1];
    end
  end

  logic [dec_pkg::MDIV_QUO_W-1:0] q1n, q2n;

  dec_div #(
    .NUM_W (dec_pkg::MDIV_NUM_W),
    .DEN_W (dec_pkg::MDIV_DEN_W),
    .QUO_W (dec_pkg::MDIV_QUO_W)
  ) u_div_m1 (
    .clk (clk), .num (mn1_r), .den (ms_r), .quo (q1n)
  );

  dec_div #(
    .NUM_W (dec_pkg::MDIV_NUM_W),
    .DEN_W (dec_pkg::MDIV_DEN_W),
    .QUO_W (dec_pkg::MDIV_QUO_W)
  ) u_div_m2 (
    .clk (clk), .num (mn2_r), .den (ms_r), .quo (q2n)
  );

  logic signed [28:0] q1s, q2s, v1n2_r, v2n2_r;
  logic [1:0]         sgn_q;

  assign q1s   = $signed({1'b0, q1n});
  assign q2s   = $signed({1'b0, q2n});
  assign sgn_q = sgn_d[ST_MQ-ST_MN];

  always_ff @(posedge clk) begin
    v1n2_r <= sgn_q[1] ? -q1s : q1s;
    v2n2_r <= sgn_q[0] ? -q2s : q2s;
  end

  // Back to x and y: products, sums, then rounding and clamping.
  logic signed [31:0] uxo, uyo;
  logic signed [60:0] bp_r [8];

  assign uxo = ux_d[ST_V2-ST_U];
  assign uyo = uy_d[ST_V2-ST_U];

  always_ff @(posedge clk) begin
    bp_r[0] <= 61'(uxo) * 61'(v1n2_r);
    bp_r[1] <= 61'(uyo) * 61'(v1t_d[ST_V2-ST_VN]);
    bp_r[2] <= 61'(uyo) * 61'(v1n2_r);
    bp_r[3] <= 61'(uxo) * 61'(v1t_d[ST_V2-ST_VN]);
    bp_r[4] <= 61'(uxo) * 61'(v2n2_r);
    bp_r[5] <= 61'(uyo) * 61'(v2t_d[ST_V2-ST_VN]);
    bp_r[6] <= 61'(uyo) * 61'(v2n2_r);
    bp_r[7] <= 61'(uxo) * 61'(v2t_d[ST_V2-ST_VN]);
  end

  logic signed [61:0] bs_r [4];

  always_ff @(posedge clk) begin
    bs_r[0] <= 62'(bp_r[0]) - 62'(bp_r[1]);
    bs_r[1] <= 62'(bp_r[2]) + 62'(bp_r[3]);
    bs_r[2] <= 62'(bp_r[4]) - 62'(bp_r[5]);
    bs_r[3] <= 62'(bp_r[6]) + 62'(bp_r[7]);
  end

  logic signed [23:0] vel_r [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      vel_r[k] <= dec_pkg::sat24(dec_pkg::rnd_shr(64'(bs_r[k])));
    end
  end

  // Output beat: resolved pairs take the new values, all others pass through.
  dec_pkg::in_t  po;
  flag_t         fo;
  dec_pkg::out_t out_nxt;
  dec_pkg::out_t out_r;

  assign po = pay_r[ST_VEL-1];
  assign fo = flag_d[ST_VEL-4];

  always_comb begin
    out_nxt.contact  = fo.contact;
    out_nxt.resolved = fo.resolve;
    if (fo.resolve) begin
      out_nxt.new_a_pos_x = dec_pkg::sat24(64'(npos_d[ST_VEL-ST_P1][0]));
      out_nxt.new_a_pos_y = dec_pkg::sat24(64'(npos_d[ST_VEL-ST_P1][1]));
      out_nxt.new_b_pos_x = dec_pkg::sat24(64'(npos_d[ST_VEL-ST_P1][2]));
      out_nxt.new_b_pos_y = dec_pkg::sat24(64'(npos_d[ST_VEL-ST_P1][3]));
      out_nxt.new_a_vel_x = vel_r[0];
      out_nxt.new_a_vel_y = vel_r[1];
      out_nxt.new_b_vel_x = vel_r[2];
      out_nxt.new_b_vel_y = vel_r[3];
    end else begin
      out_nxt.new_a_pos_x = po.a_pos_x;
      out_nxt.new_a_pos_y = po.a_pos_y;
      out_nxt.new_b_pos_x = po.b_pos_x;
      out_nxt.new_b_pos_y = po.b_pos_y;
      out_nxt.new_a_vel_x = po.a_vel_x;
      out_nxt.new_a_vel_y = po.a_vel_y;
      out_nxt.new_b_vel_x = po.b_vel_x;
      out_nxt.new_b_vel_y = po.b_vel_y;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[ST_OUT-1];

  // --------------------------------------------------------------------------
  // Checks.

  // Every result beat goes back to a matching input beat.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, ST_OUT))
    else $error("result beat without a matching input beat");

  // A resolved pair is always in contact.
  a_resolved_contact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.resolved |-> out_data.contact)
    else $error("resolved without contact");

  // For a live resolved beat the root never exceeds the diameter.
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DQ-1] && flag_d[ST_DQ-4].resolve |-> dq <= {dfix, 7'd0})
    else $error("distance root above diameter");

  // For a resolved beat the x part of the unit normal stays within one in Q30.
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flag_d[ST_U-4].resolve |->
      (ux_d[0] <= 32'sd1073741824) && (ux_d[0] >= -32'sd1073741824))
    else $error("unit normal out of range");

endmodule
